// File: rtl/mtg_pkg.sv
// Package with the shared constants, types and helper functions of the MT19937 generator.
`default_nettype none

package mtg_pkg;

  localparam int WORD_W        = 32;
  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int IDX_W         = $clog2(STATE_WORDS);
  localparam int CNT_W         = $clog2(WORD_W);
  localparam int OP_W          = 2;

  localparam logic [IDX_W-1:0] POS_EXHAUSTED = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] FIRST_MID     = IDX_W'(MIDDLE_OFFSET);

  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [7:0]        EXP_BIAS_M32 = 8'd95;

  typedef enum logic [OP_W-1:0] {
    OP_RESEED,
    OP_RAW,
    OP_MOD,
    OP_FLOAT
  } mtg_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_TW_START,
    ST_TW_LOAD,
    ST_TW_RUN,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_DISPATCH,
    ST_DIV,
    ST_FLT,
    ST_FINISH
  } mtg_state_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } mtg_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
  } mtg_rd_t;

  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] j);
    logic [IDX_W-1:0] r;
    r = (j == LAST_IDX) ? '0 : j + IDX_W'(1);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] mid_index(input logic [IDX_W-1:0] j);
    logic [IDX_W:0] s;
    s = {1'b0, j} + (IDX_W+1)'(MIDDLE_OFFSET);
    if (s >= (IDX_W+1)'(STATE_WORDS)) begin
      s = s - (IDX_W+1)'(STATE_WORDS);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    v = w;
    v = v ^ (v >> 11);
    v = v ^ ((v << 7) & TEMPER_B);
    v = v ^ ((v << 15) & TEMPER_C);
    v = v ^ (v >> 18);
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mtg_state_ram.sv
// State word memory with one write port and two registered read ports.
`default_nettype none

module mtg_state_ram
  import mtg_pkg::*;
(
  input  wire logic              clk,
  input  wire mtg_wr_t           wr,
  input  wire mtg_rd_t           rd,
  output logic      [WORD_W-1:0] rdata_a,
  output logic      [WORD_W-1:0] rdata_b
);

  logic [WORD_W-1:0] mem [STATE_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[rd.addr_a];
    rdata_b <= mem[rd.addr_b];
  end

endmodule

`default_nettype wire

// File: rtl/mtg_divider.sv
// Restoring remainder unit that retires one dividend bit per cycle.
`default_nettype none

module mtg_divider
  import mtg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   done,
  output logic      [WORD_W-1:0] remainder
);

  logic              busy;
  logic [CNT_W-1:0]  count;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] dsr;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  assign trial = {remainder, dvd[WORD_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count     <= CNT_W'(WORD_W - 1);
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      count <= count - CNT_W'(1);
      dvd   <= dvd << 1;
      if (!diff[WORD_W]) begin
        remainder <= diff[WORD_W-1:0];
      end else begin
        remainder <= trial[WORD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mtg_float.sv
// Word to single-precision converter that normalizes by one bit per cycle, then rounds.
`default_nettype none

module mtg_float
  import mtg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] word,
  output logic                   done,
  output logic      [WORD_W-1:0] bits
);

  logic              busy;
  logic [WORD_W-1:0] norm;
  logic [CNT_W-1:0]  msb;
  logic              round_up;
  logic [24:0]       mant;
  logic              carry;
  logic [7:0]        expo;
  logic [22:0]       frac;

  assign round_up = norm[7] && ((|norm[6:0]) || norm[8]);
  assign mant     = {1'b0, norm[31:8]} + 25'(round_up);
  assign carry    = mant[24];
  assign expo     = {3'b000, msb} + EXP_BIAS_M32 + 8'(carry);
  assign frac     = carry ? '0 : mant[22:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= (word != '0);
        done <= (word == '0);
      end else if (busy && norm[WORD_W-1]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      norm <= word;
      msb  <= CNT_W'(WORD_W - 1);
      bits <= '0;
    end else if (busy) begin
      if (norm[WORD_W-1]) begin
        bits <= {1'b0, expo, frac};
      end else begin
        norm <= norm << 1;
        msb  <= msb - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mt19937_generator.sv
// Top level of the MT19937 generator: sequencer, state memory, remainder and float units.
// A raw draw runs the read issue, read wait, dispatch and finish states; a bounded draw adds the
// remainder unit (one remainder bit per cycle) unless the bound is zero, and a float draw adds the
// float unit (one normalize step per cycle). A draw that finds the state exhausted first runs a
// twist pass, one word per cycle through the dual-read state memory; a reseed writes each word
// through the seed multiply and add states. Input is ready again when the result registers;
// rst clears the sequencer, read position and seeded flag, and state words stay unknown until seeded.
`default_nettype none

module mt19937_generator
  import mtg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // bound
  input  wire logic [1:0]  s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // result_value
  output logic      [0:0]  m_axis_tuser    // bad_bound
);

  mtg_state_t        state, state_next;
  mtg_op_t           op, op_next;
  logic [WORD_W-1:0] bound, bound_next;
  logic [WORD_W-1:0] seed, seed_next;
  logic              seeded, seeded_next;
  logic [IDX_W-1:0]  pos, pos_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [WORD_W-1:0] prev, prev_next;
  logic [WORD_W-1:0] prod, prod_next;
  logic [WORD_W-1:0] word, word_next;
  logic [WORD_W-1:0] result, result_next;
  logic              bad, bad_next;
  logic              out_valid, out_valid_next;
  logic [WORD_W-1:0] out_data, out_data_next;
  logic              out_bad, out_bad_next;

  mtg_wr_t           wr;
  mtg_rd_t           rd;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;
  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_rem;
  logic              flt_start;
  logic              flt_done;
  logic [WORD_W-1:0] flt_bits;
  logic [WORD_W-1:0] twist_y;
  logic [WORD_W-1:0] twist_word;
  logic [WORD_W-1:0] seed_word;
  logic              in_fire;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_bad;

  assign twist_y    = {prev[WORD_W-1], rdata_a[WORD_W-2:0]};
  assign twist_word = rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);
  assign seed_word  = prod + {{(WORD_W-IDX_W){1'b0}}, idx};

  mtg_state_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mtg_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (word),
    .divisor   (bound),
    .done      (div_done),
    .remainder (div_rem)
  );

  mtg_float u_flt (
    .clk   (clk),
    .rst   (rst),
    .start (flt_start),
    .word  (word),
    .done  (flt_done),
    .bits  (flt_bits)
  );

  always_comb begin
    state_next     = state;
    op_next        = op;
    bound_next     = bound;
    seed_next      = seed;
    seeded_next    = seeded;
    pos_next       = pos;
    idx_next       = idx;
    prev_next      = prev;
    prod_next      = prod;
    word_next      = word;
    result_next    = result;
    bad_next       = bad;
    out_valid_next = out_valid && !m_axis_tready;
    out_data_next  = out_data;
    out_bad_next   = out_bad;
    wr             = '0;
    rd             = '0;
    div_start      = 1'b0;
    flt_start      = 1'b0;

    if (cfg_valid && cfg_ready) begin
      seed_next = cfg_data;
    end

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          op_next     = mtg_op_t'(s_axis_tuser);
          bound_next  = s_axis_tdata;
          result_next = '0;
          bad_next    = 1'b0;
          if (mtg_op_t'(s_axis_tuser) == OP_RESEED || !seeded) begin
            state_next = ST_SEED_INIT;
          end else if (pos == POS_EXHAUSTED) begin
            state_next = ST_TW_START;
          end else begin
            state_next = ST_RD_ISSUE;
          end
        end
      end
      ST_SEED_INIT: begin
        wr.en      = 1'b1;
        wr.addr    = '0;
        wr.data    = seed;
        prev_next  = seed;
        idx_next   = IDX_W'(1);
        state_next = ST_SEED_MUL;
      end
      ST_SEED_MUL: begin
        prod_next  = SEED_MULT * (prev ^ (prev >> 30));
        state_next = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        wr.en     = 1'b1;
        wr.addr   = idx;
        wr.data   = seed_word;
        prev_next = seed_word;
        if (idx == LAST_IDX) begin
          pos_next    = POS_EXHAUSTED;
          seeded_next = 1'b1;
          state_next  = (op == OP_RESEED) ? ST_FINISH : ST_TW_START;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = ST_SEED_MUL;
        end
      end
      ST_TW_START: begin
        rd.addr_a  = '0;
        state_next = ST_TW_LOAD;
      end
      ST_TW_LOAD: begin
        prev_next  = rdata_a;
        rd.addr_a  = next_index('0);
        rd.addr_b  = FIRST_MID;
        idx_next   = '0;
        state_next = ST_TW_RUN;
      end
      ST_TW_RUN: begin
        wr.en     = 1'b1;
        wr.addr   = idx;
        wr.data   = twist_word;
        prev_next = rdata_a;
        if (idx == LAST_IDX) begin
          pos_next   = '0;
          state_next = ST_RD_ISSUE;
        end else begin
          idx_next  = idx + IDX_W'(1);
          rd.addr_a = next_index(idx + IDX_W'(1));
          rd.addr_b = mid_index(idx + IDX_W'(1));
        end
      end
      ST_RD_ISSUE: begin
        rd.addr_a  = pos;
        state_next = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        word_next  = temper(rdata_a);
        pos_next   = pos + IDX_W'(1);
        state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (op)
          OP_RAW: begin
            result_next = word;
            state_next  = ST_FINISH;
          end
          OP_MOD: begin
            if (bound == '0) begin
              bad_next   = 1'b1;
              state_next = ST_FINISH;
            end else begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          end
          OP_FLOAT: begin
            flt_start  = 1'b1;
            state_next = ST_FLT;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          result_next = div_rem;
          state_next  = ST_FINISH;
        end
      end
      ST_FLT: begin
        if (flt_done) begin
          result_next = flt_bits;
          state_next  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = result;
          out_bad_next   = bad;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seed      <= SEED_RESET;
      seeded    <= 1'b0;
      pos       <= POS_EXHAUSTED;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      seed      <= seed_next;
      seeded    <= seeded_next;
      pos       <= pos_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    bound    <= bound_next;
    idx      <= idx_next;
    prev     <= prev_next;
    prod     <= prod_next;
    word     <= word_next;
    result   <= result_next;
    bad      <= bad_next;
    out_data <= out_data_next;
    out_bad  <= out_bad_next;
  end

  assert property (@(posedge clk) disable iff (rst) pos <= POS_EXHAUSTED)
    else $error("Read position ran past the end of the state.");

  assert property (@(posedge clk) disable iff (rst) seeded |=> seeded)
    else $error("Seeded flag dropped without a reset.");

  assert property (@(posedge clk) disable iff (rst) div_start |-> bound != '0)
    else $error("Remainder unit started with a zero bound.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_TW_RUN && idx == LAST_IDX) |=> (pos == '0 && state == ST_RD_ISSUE))
    else $error("Twist pass did not rewind the read position.");

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench for the MT19937 generator: directed and random draws checked against a predictor.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtg_pkg::*;

  localparam int          NUM_WORDS     = 624;
  localparam int          MID_STEP      = 397;
  localparam logic [31:0] MULT_SEED     = 32'd1812433253;
  localparam logic [31:0] MASK_B        = 32'h9d2c_5680;
  localparam logic [31:0] MASK_C        = 32'hefc6_0000;
  localparam logic [31:0] TWIST_POLY    = 32'h9908_b0df;
  localparam logic [31:0] DEFAULT_SEED  = 32'd5489;
  localparam int          RESET_CYCLES  = 11;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PHASE_ITEMS   = 330;
  localparam int          PRESSURE_ITEMS = 150;

  typedef struct {
    mtg_op_t     op;
    logic [31:0] bound;
  } draw_request_t;

  typedef struct {
    logic [31:0] value;
    logic        bad_bound;
  } draw_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // bound
  logic [1:0]  s_axis_tuser = '0;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // result_value
  logic [0:0]  m_axis_tuser;        // bad_bound

  draw_request_t request_queue[$];
  draw_result_t  expected_draws[$];

  logic [31:0] mt_words[NUM_WORDS];
  int unsigned mt_pos = NUM_WORDS;
  bit          mt_seeded = 1'b0;
  logic [31:0] seed_reg = DEFAULT_SEED;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  request_taken = 1'b0;
  bit  pressure_req = 1'b0;
  bit  pressure_done = 1'b0;
  int  hold_count = 0;
  int  mismatch_count = 0;
  int  op_count[4] = '{0, 0, 0, 0};
  int  zero_bound_count = 0;
  int  seed_writes = 0;
  int  seedings = 0;
  int  twist_passes = 0;

  mt19937_generator i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void load_state(input logic [31:0] s);
    logic [31:0] p;
    int          i;
    mt_words[0] = s;
    for (i = 1; i < NUM_WORDS; i++) begin
      p = mt_words[i-1];
      mt_words[i] = MULT_SEED * (p ^ (p >> 30)) + 32'(i);
    end
    mt_pos = NUM_WORDS;
    mt_seeded = 1'b1;
    seedings++;
  endfunction

  function automatic void twist_state();
    logic [31:0] y;
    int          i;
    for (i = 0; i < NUM_WORDS; i++) begin
      y = (mt_words[i] & 32'h8000_0000) | (mt_words[(i + 1) % NUM_WORDS] & 32'h7fff_ffff);
      mt_words[i] = mt_words[(i + MID_STEP) % NUM_WORDS] ^ (y >> 1) ^
                    (y[0] ? TWIST_POLY : 32'h0);
    end
    mt_pos = 0;
    twist_passes++;
  endfunction

  function automatic logic [31:0] next_word();
    logic [31:0] v;
    if (!mt_seeded) begin
      load_state(seed_reg);
    end
    if (mt_pos >= NUM_WORDS) begin
      twist_state();
    end
    v = mt_words[mt_pos];
    mt_pos++;
    v = v ^ (v >> 11);
    v = v ^ ((v << 7) & MASK_B);
    v = v ^ ((v << 15) & MASK_C);
    v = v ^ (v >> 18);
    return v;
  endfunction

  // Nearest single-precision value to w / 2^32, ties to even.
  function automatic logic [31:0] unit_float_bits(input logic [31:0] w);
    int          top;
    int          sh;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    if (w == 32'h0) begin
      return 32'h0;
    end
    top = 31;
    while (!w[top]) begin
      top--;
    end
    if (top <= 23) begin
      mant = w << (23 - top);
    end else begin
      sh = top - 23;
      rem = w & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      mant = w >> sh;
      if (rem > half || (rem == half && mant[0])) begin
        mant++;
      end
      if (mant == 32'h0100_0000) begin
        mant = mant >> 1;
        top++;
      end
    end
    return {1'b0, 8'(top + 95), mant[22:0]};
  endfunction

  function automatic draw_result_t predict_draw(input draw_request_t req);
    draw_result_t r;
    logic [31:0]  w;
    r.value = '0;
    r.bad_bound = 1'b0;
    case (req.op)
      OP_RESEED: begin
        load_state(seed_reg);
      end
      OP_RAW: begin
        r.value = next_word();
      end
      OP_MOD: begin
        w = next_word();
        if (req.bound == 32'h0) begin
          r.bad_bound = 1'b1;
        end else begin
          r.value = w % req.bound;
        end
      end
      default: begin
        r.value = unit_float_bits(next_word());
      end
    endcase
    return r;
  endfunction

  function automatic draw_request_t random_request();
    draw_request_t r;
    int            pick;
    pick = $urandom_range(99);
    if (pick < 2) begin
      r.op = OP_RESEED;
    end else if (pick < 34) begin
      r.op = OP_RAW;
    end else if (pick < 70) begin
      r.op = OP_MOD;
    end else begin
      r.op = OP_FLOAT;
    end
    pick = $urandom_range(99);
    if (pick < 5) begin
      r.bound = 32'h0;
    end else if (pick < 30) begin
      r.bound = $urandom_range(16, 1);
    end else if (pick < 40) begin
      r.bound = 32'd1 << $urandom_range(31);
    end else if (pick < 48) begin
      r.bound = 32'hffff_ffff - $urandom_range(7);
    end else begin
      r.bound = $urandom();
    end
    return r;
  endfunction

  task automatic queue_request(input mtg_op_t op, input logic [31:0] bound);
    draw_request_t r;
    r.op = op;
    r.bound = bound;
    request_queue.push_back(r);
  endtask

  task automatic write_seed(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    seed_reg = value;
    seed_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (request_queue.size() != 0 || expected_draws.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !request_taken) begin
      s_axis_tvalid <= 1'b1;
    end else if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= request_queue[0].bound;
      s_axis_tuser <= request_queue[0].op;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst || (pressure_req && !pressure_done)) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (pressure_req && !pressure_done) begin
      if (hold_count == HOLD_CYCLES) begin
        pressure_done = 1'b1;
      end else begin
        hold_count++;
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    draw_result_t  want;
    draw_request_t req;
    if (rst) begin
      request_taken = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_draws.size() == 0) begin
          $error("result 0x%08h arrived with no request waiting", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = expected_draws.pop_front();
          if (m_axis_tdata !== want.value) begin
            $error("result_value: expected 0x%08h, got 0x%08h", want.value, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tuser[0] !== want.bad_bound) begin
            $error("bad_bound: expected %0b, got %0b", want.bad_bound, m_axis_tuser[0]);
            mismatch_count++;
          end
        end
      end
      request_taken = s_axis_tvalid && s_axis_tready;
      if (request_taken) begin
        req = request_queue.pop_front();
        op_count[int'(req.op)]++;
        if (req.op == OP_MOD && req.bound == 32'h0) begin
          zero_bound_count++;
        end
        expected_draws.push_back(predict_draw(req));
      end
    end
  end

  initial begin
    int phase;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first draw seeds itself from the reset value of the seed register.
    queue_request(OP_RAW, $urandom());
    queue_request(OP_MOD, 32'h0);
    queue_request(OP_MOD, 32'h1);
    queue_request(OP_MOD, 32'hffff_ffff);
    queue_request(OP_MOD, 32'h8000_0000);
    queue_request(OP_MOD, 32'h3);
    queue_request(OP_FLOAT, 32'h0);
    queue_request(OP_FLOAT, 32'hffff_ffff);
    queue_request(OP_RESEED, 32'hffff_ffff);
    queue_request(OP_RAW, 32'h0);
    wait_idle();

    // A new seed must not disturb the running sequence until the next reseed.
    write_seed(32'h0);
    queue_request(OP_RAW, 32'h0);
    queue_request(OP_RESEED, 32'h0);
    queue_request(OP_RAW, 32'hffff_ffff);
    queue_request(OP_MOD, 32'h7);
    queue_request(OP_FLOAT, 32'h5555_5555);
    wait_idle();

    write_seed(32'hffff_ffff);
    queue_request(OP_RESEED, 32'h0);
    queue_request(OP_RAW, 32'haaaa_aaaa);
    queue_request(OP_MOD, 32'h0);
    queue_request(OP_FLOAT, 32'h0);
    queue_request(OP_MOD, 32'hffff_ffff);
    wait_idle();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 60;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 60;
        end
        default: begin
          send_idle_pct = 12;
          recv_stall_pct = 12;
        end
      endcase
      if (phase == 2) begin
        write_seed(DEFAULT_SEED);
      end else if (phase != 1) begin
        write_seed($urandom());
      end
      repeat (PHASE_ITEMS) request_queue.push_back(random_request());
      wait_idle();
    end

    // The receiver holds off for a long stretch while requests keep coming.
    write_seed(32'h8000_0000);
    send_idle_pct = 0;
    recv_stall_pct = 20;
    pressure_req = 1'b1;
    repeat (PRESSURE_ITEMS) request_queue.push_back(random_request());
    wait_idle();

    $display("Covered %0d reseeds, %0d raw, %0d bounded (%0d with zero bound), %0d float draws.",
             op_count[int'(OP_RESEED)], op_count[int'(OP_RAW)], op_count[int'(OP_MOD)],
             zero_bound_count, op_count[int'(OP_FLOAT)]);
    $display("Wrote %0d seeds, seeded the state %0d times and twisted it %0d times.",
             seed_writes, seedings, twist_passes);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/mtg_pkg.sv
rtl/mtg_state_ram.sv
rtl/mtg_divider.sv
rtl/mtg_float.sv
rtl/mt19937_generator.sv
dv/tb.sv
